[sv/hmt_pkg.sv]
// Shared types and codes for the heartbeat membership table.
package hmt_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_MERGE   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_DUMP    = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_UPDATED   = 3'd1;
    localparam logic [2:0] KIND_UNCHANGED = 3'd2;
    localparam logic [2:0] KIND_DROPPED   = 3'd3;
    localparam logic [2:0] KIND_REMOVED   = 3'd4;
    localparam logic [2:0] KIND_LISTED    = 3'd5;
    localparam logic [2:0] KIND_EMPTY     = 3'd6;
    localparam logic [2:0] KIND_RESTARTED = 3'd7;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    // One table entry as held by a cell.
    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] heartbeat;
        logic [31:0] stamp;
    } entry_t;

    // One input item.
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] node_id;
        logic [15:0] node_port;
        logic [31:0] heartbeat_in;
        logic [31:0] current_time;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] entry_id;
        logic [15:0] entry_port;
        logic [31:0] entry_heartbeat;
        logic        is_self;
        logic [5:0]  entry_count;
        logic        last;
    } result_t;

    // Per-cell control: take the neighbor's entry, or load the broadcast entry.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

[sv/hmt_cell.sv]
// One cell of the membership chain: holds a single table entry.
module hmt_cell (
    input  logic               clk,
    input  hmt_pkg::cell_ctrl_t ctrl,
    input  hmt_pkg::entry_t    nbr,
    input  hmt_pkg::entry_t    load_data,
    output hmt_pkg::entry_t    q
);

    hmt_pkg::entry_t q_reg;
    hmt_pkg::entry_t q_next;

    // The cell either takes its neighbor's entry as the chain advances, takes the
    // broadcast entry when it is the write position, or holds.
    always_comb
    begin
        priority if (ctrl.shift)
        begin
            q_next = nbr;
        end
        else if (ctrl.load)
        begin
            q_next = load_data;
        end
        else
        begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[sv/heartbeat_membership_table_top.sv]
// Top level of the heartbeat membership table: control sequencer and the chain of cells.
// One item at a time: busy falls in the cycle that shows the last result; a restart never
// raises it. The chain shows one entry per cycle at its head; the receiver cannot stall.
// rst_n clears entry count, own heartbeat and self address, resets timeout, not entries.
module heartbeat_membership_table_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hmt_pkg::cmd_t                     cmd,
    output logic                              result_strobe,
    output hmt_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [hmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states. Each pass walks the chain once, one entry per cycle.
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_MERGE     = 6'b000010,
        S_MERGE_END = 6'b000100,
        S_MARK      = 6'b001000,
        S_PURGE     = 6'b010000,
        S_LIST      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    hmt_pkg::cmd_t    cmd_reg, cmd_next;
    hmt_pkg::result_t res_reg, res_next;
    logic             strobe_reg, strobe_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic [CNT_W-1:0] drop_reg, drop_next;
    logic             found_reg, found_next;
    logic [31:0]      found_hb_reg, found_hb_next;
    logic [31:0]      own_hb_reg, own_hb_next;

    logic [31:0]      self_id_reg, self_id_next;
    logic [15:0]      self_port_reg, self_port_next;
    logic [15:0]      timeout_reg, timeout_next;

    // Chain signals.
    hmt_pkg::entry_t     cell_q [TABLE_DEPTH];
    hmt_pkg::cell_ctrl_t cell_ctrl [TABLE_DEPTH];
    hmt_pkg::entry_t     head;
    hmt_pkg::entry_t     load_data;
    logic                shift;
    logic                load;
    logic [CNT_W-1:0]    load_idx;

    // Head evaluation.
    logic        head_self;
    logic        head_match;
    logic        head_gone;
    logic [31:0] head_age;
    logic        cmd_self;
    logic        zero_self;

    assign head      = cell_q[0];
    assign head_self = (head.id == self_id_reg) && (head.port == self_port_reg);
    assign head_match = (head.id == cmd_reg.node_id) && (head.port == cmd_reg.node_port);
    assign head_age  = cmd_reg.current_time - head.stamp;
    // A peer ages out once its silence reaches the timeout; this node's own entry never does.
    assign head_gone = !head_self && (head_age >= {16'd0, timeout_reg});
    assign cmd_self  = (cmd_reg.node_id == self_id_reg) && (cmd_reg.node_port == self_port_reg);
    // The empty result carries id 0 and port 0, which may happen to be this node's address.
    assign zero_self = (self_id_reg == 32'd0) && (self_port_reg == 16'd0);

    assign busy = (state_reg != S_IDLE);

    // The chain works as a queue whose head is cell 0. Shifting moves every valid cell one
    // place toward the head; the entry popped from the head is either written back at the
    // tail (cell count-1) or, when it is removed, dropped while the count shrinks. A full
    // pass over N entries therefore leaves the survivors in their original order.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        strobe_next    = 1'b0;
        count_next     = count_reg;
        scan_next      = scan_reg;
        keep_next      = keep_reg;
        drop_next      = drop_reg;
        found_next     = found_reg;
        found_hb_next  = found_hb_reg;
        own_hb_next    = own_hb_reg;
        self_id_next   = self_id_reg;
        self_port_next = self_port_reg;
        timeout_next   = timeout_reg;
        shift          = 1'b0;
        load           = 1'b0;
        load_idx       = count_reg - CNT_W'(1);
        load_data      = head;

        if (cfg_we)
        begin
            if (cfg_index == hmt_pkg::CFG_SELF_ID)
            begin
                self_id_next = cfg_data;
            end
            else if (cfg_index == hmt_pkg::CFG_SELF_PORT)
            begin
                self_port_next = cfg_data[15:0];
            end
            else if (cfg_index == hmt_pkg::CFG_TIMEOUT)
            begin
                timeout_next = cfg_data[15:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    scan_next = count_reg;
                    unique case (cmd.operation)
                        hmt_pkg::OP_MERGE:
                        begin
                            found_next = 1'b0;
                            state_next = S_MERGE;
                        end
                        hmt_pkg::OP_TICK:
                        begin
                            keep_next = '0;
                            if (own_hb_reg != 32'hFFFF_FFFF)
                            begin
                                own_hb_next = own_hb_reg + 32'd1;
                            end
                            state_next = S_MARK;
                        end
                        hmt_pkg::OP_DUMP:
                        begin
                            state_next = S_LIST;
                        end
                        hmt_pkg::OP_RESTART:
                        begin
                            // The table restarts with only this node's own entry.
                            load                     = 1'b1;
                            load_idx                 = '0;
                            load_data.id             = self_id_reg;
                            load_data.port           = self_port_reg;
                            load_data.heartbeat      = 32'd0;
                            load_data.stamp          = cmd.current_time;
                            count_next               = CNT_W'(1);
                            scan_next                = '0;
                            own_hb_next              = 32'd0;
                            strobe_next              = 1'b1;
                            res_next.kind            = hmt_pkg::KIND_RESTARTED;
                            res_next.entry_id        = self_id_reg;
                            res_next.entry_port      = self_port_reg;
                            res_next.entry_heartbeat = 32'd0;
                            res_next.is_self         = 1'b1;
                            res_next.entry_count     = 6'd1;
                            res_next.last            = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_MERGE:
            begin
                if (scan_reg == '0)
                begin
                    state_next = S_MERGE_END;
                end
                else
                begin
                    // Rotate the head to the tail, updating it when it is the merged
                    // address and the reported heartbeat is newer.
                    shift     = 1'b1;
                    load      = 1'b1;
                    scan_next = scan_reg - CNT_W'(1);
                    if (head_match && !found_reg)
                    begin
                        found_next    = 1'b1;
                        found_hb_next = head.heartbeat;
                        if (head.heartbeat < cmd_reg.heartbeat_in)
                        begin
                            load_data.heartbeat = cmd_reg.heartbeat_in;
                            load_data.stamp     = cmd_reg.current_time;
                        end
                    end
                end
            end

            S_MERGE_END:
            begin
                strobe_next              = 1'b1;
                res_next.entry_id        = cmd_reg.node_id;
                res_next.entry_port      = cmd_reg.node_port;
                res_next.entry_heartbeat = cmd_reg.heartbeat_in;
                res_next.is_self         = cmd_self;
                res_next.entry_count     = 6'(count_reg);
                res_next.last            = 1'b1;
                state_next               = S_IDLE;
                if (found_reg)
                begin
                    if (found_hb_reg < cmd_reg.heartbeat_in)
                    begin
                        res_next.kind = hmt_pkg::KIND_UPDATED;
                    end
                    else
                    begin
                        res_next.kind            = hmt_pkg::KIND_UNCHANGED;
                        res_next.entry_heartbeat = found_hb_reg;
                    end
                end
                else if (count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    // Append a new member right behind the last valid entry.
                    load                 = 1'b1;
                    load_idx             = count_reg;
                    load_data.id         = cmd_reg.node_id;
                    load_data.port       = cmd_reg.node_port;
                    load_data.heartbeat  = cmd_reg.heartbeat_in;
                    load_data.stamp      = cmd_reg.current_time;
                    count_next           = count_reg + CNT_W'(1);
                    res_next.kind        = hmt_pkg::KIND_ADDED;
                    res_next.entry_count = 6'(count_reg + CNT_W'(1));
                end
                else
                begin
                    res_next.kind = hmt_pkg::KIND_DROPPED;
                end
            end

            S_MARK:
            begin
                // First tick pass: count survivors so that every removal result can carry
                // the final entry count, and refresh this node's own entry on the way.
                if (scan_reg == '0)
                begin
                    drop_next = count_reg - keep_reg;
                    scan_next = count_reg;
                    if (keep_reg == count_reg)
                    begin
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_PURGE;
                    end
                end
                else
                begin
                    shift     = 1'b1;
                    load      = 1'b1;
                    scan_next = scan_reg - CNT_W'(1);
                    if (!head_gone)
                    begin
                        keep_next = keep_reg + CNT_W'(1);
                    end
                    if (head_self)
                    begin
                        load_data.heartbeat = own_hb_reg;
                        load_data.stamp     = cmd_reg.current_time;
                    end
                end
            end

            S_PURGE:
            begin
                // Second tick pass: report and drop aged peers, keep the rest in order.
                if (scan_reg == '0)
                begin
                    scan_next = count_reg;
                    if (count_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LIST;
                    end
                end
                else
                begin
                    shift     = 1'b1;
                    scan_next = scan_reg - CNT_W'(1);
                    if (head_gone)
                    begin
                        count_next               = count_reg - CNT_W'(1);
                        drop_next                = drop_reg - CNT_W'(1);
                        strobe_next              = 1'b1;
                        res_next.kind            = hmt_pkg::KIND_REMOVED;
                        res_next.entry_id        = head.id;
                        res_next.entry_port      = head.port;
                        res_next.entry_heartbeat = head.heartbeat;
                        res_next.is_self         = head_self;
                        res_next.entry_count     = 6'(keep_reg);
                        res_next.last            = (keep_reg == '0) && (drop_reg == CNT_W'(1));
                        // When nothing survives, the last removal ends the item.
                        if ((keep_reg == '0) && (drop_reg == CNT_W'(1)))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        load = 1'b1;
                    end
                end
            end

            S_LIST:
            begin
                strobe_next          = 1'b1;
                res_next.entry_count = 6'(count_reg);
                if (count_reg == '0)
                begin
                    // Nothing to list and nothing removed: one empty result.
                    res_next.kind            = hmt_pkg::KIND_EMPTY;
                    res_next.entry_id        = 32'd0;
                    res_next.entry_port      = 16'd0;
                    res_next.entry_heartbeat = 32'd0;
                    res_next.is_self         = zero_self;
                    res_next.last            = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    shift                    = 1'b1;
                    load                     = 1'b1;
                    scan_next                = scan_reg - CNT_W'(1);
                    res_next.kind            = hmt_pkg::KIND_LISTED;
                    res_next.entry_id        = head.id;
                    res_next.entry_port      = head.port;
                    res_next.entry_heartbeat = head.heartbeat;
                    res_next.is_self         = head_self;
                    res_next.last            = (scan_reg == CNT_W'(1));
                    if (scan_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Cell enables: cells in front of the tail advance; the write position loads.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cell_ctrl[i].shift = shift && ((CNT_W'(i) + CNT_W'(1)) < count_reg);
            cell_ctrl[i].load  = load && (CNT_W'(i) == load_idx);
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        hmt_pkg::entry_t nbr;
        if (g == TABLE_DEPTH - 1)
        begin : g_end
            assign nbr = cell_q[g];
        end
        else
        begin : g_mid
            assign nbr = cell_q[g+1];
        end

        hmt_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[g]),
            .nbr       (nbr),
            .load_data (load_data),
            .q         (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            strobe_reg    <= 1'b0;
            count_reg     <= '0;
            scan_reg      <= '0;
            keep_reg      <= '0;
            drop_reg      <= '0;
            found_reg     <= 1'b0;
            own_hb_reg    <= '0;
            self_id_reg   <= '0;
            self_port_reg <= '0;
            timeout_reg   <= hmt_pkg::TIMEOUT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            strobe_reg    <= strobe_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            keep_reg      <= keep_next;
            drop_reg      <= drop_next;
            found_reg     <= found_next;
            own_hb_reg    <= own_hb_next;
            self_id_reg   <= self_id_next;
            self_port_reg <= self_port_next;
            timeout_reg   <= timeout_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        found_hb_reg <= found_hb_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

`ifndef SYNTHESIS
    // The table never holds more entries than the chain has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // A pass never has more entries left to visit than the table holds.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= count_reg)
        else $error("scan counter ahead of entry count");

    // The final result of an item appears only once the sequencer is free again.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> !busy)
        else $error("last result while still busy");

    // Every accepted item other than a restart occupies the sequencer.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.operation != hmt_pkg::OP_RESTART)) |=> busy)
        else $error("accepted item did not start a pass");
`endif

endmodule

[dv/tb_heartbeat_membership_table_top.sv]
// Self-checking testbench for the heartbeat membership table top level.
`timescale 1ns / 100ps

module tb_heartbeat_membership_table_top;

    localparam int TABLE_DEPTH = 32;
    localparam int POOL_SIZE = 40;
    // The longest item is a tick over a full table and the sender's gaps are short,
    // so reaching the limit without any handshake means a hang.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles to keep watching for stray results once nothing is expected.
    localparam int DRAIN_CYCLES = 3 * TABLE_DEPTH + 8;

    // Clock, reset and the block's ports.
    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    hmt_pkg::cmd_t cmd;
    logic result_strobe;
    hmt_pkg::result_t result;
    logic cfg_we;
    logic [hmt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hmt_pkg::CFG_DATA_W-1:0] cfg_data;

    // Predicted copy of the membership table and of the configuration.
    hmt_pkg::entry_t member_tab [TABLE_DEPTH];
    int unsigned member_cnt;
    logic [31:0] own_beat;
    logic [31:0] cfg_self_id;
    logic [15:0] cfg_self_port;
    logic [15:0] cfg_timeout;

    // Reports predicted for accepted items, oldest first.
    hmt_pkg::result_t expected_reports [$];

    // Bookkeeping for checking and for the random traffic.
    int mismatch_count;
    int reports_seen;
    int stall_cycles;
    bit no_idle;
    logic [31:0] time_now;
    logic [31:0] pool_id [POOL_SIZE];
    logic [15:0] pool_port [POOL_SIZE];
    logic [31:0] pool_beat [POOL_SIZE];

    heartbeat_membership_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .result_strobe(result_strobe),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // An address is this node's own when both id and port match the registers.
    function automatic bit is_own_address(logic [31:0] id, logic [15:0] port);
        return (id == cfg_self_id) && (port == cfg_self_port);
    endfunction

    // Builds one report; the entry count and the last flag are filled in later,
    // once the whole item has been worked out.
    function automatic hmt_pkg::result_t make_report(logic [2:0] kind, logic [31:0] id,
                                                     logic [15:0] port, logic [31:0] beat);
        hmt_pkg::result_t r;
        r.kind = kind;
        r.entry_id = id;
        r.entry_port = port;
        r.entry_heartbeat = beat;
        r.is_self = is_own_address(id, port);
        r.entry_count = '0;
        r.last = 1'b0;
        return r;
    endfunction

    // Applies one accepted item to the predicted table and queues its reports.
    function automatic void predict_table_op(hmt_pkg::cmd_t c);
        hmt_pkg::result_t batch [$];
        hmt_pkg::result_t r;
        bit found;
        int slot;
        int unsigned keep;
        logic [31:0] age;
        found = 1'b0;
        slot = 0;
        keep = 0;
        case (c.operation)
            hmt_pkg::OP_MERGE:
            begin
                for (int i = 0; i < member_cnt; i++)
                begin
                    if (!found && member_tab[i].id == c.node_id
                        && member_tab[i].port == c.node_port)
                    begin
                        found = 1'b1;
                        slot = i;
                    end
                end
                if (!found && member_cnt < TABLE_DEPTH)
                begin
                    member_tab[member_cnt] = '{c.node_id, c.node_port, c.heartbeat_in,
                                               c.current_time};
                    member_cnt++;
                    batch.insert(batch.size(), make_report(hmt_pkg::KIND_ADDED, c.node_id,
                                                           c.node_port, c.heartbeat_in));
                end
                else if (!found)
                begin
                    batch.insert(batch.size(), make_report(hmt_pkg::KIND_DROPPED, c.node_id,
                                                           c.node_port, c.heartbeat_in));
                end
                else if (member_tab[slot].heartbeat < c.heartbeat_in)
                begin
                    member_tab[slot].heartbeat = c.heartbeat_in;
                    member_tab[slot].stamp = c.current_time;
                    batch.insert(batch.size(), make_report(hmt_pkg::KIND_UPDATED, c.node_id,
                                                           c.node_port, c.heartbeat_in));
                end
                else
                begin
                    batch.insert(batch.size(), make_report(hmt_pkg::KIND_UNCHANGED,
                                                           c.node_id, c.node_port,
                                                           member_tab[slot].heartbeat));
                end
            end
            hmt_pkg::OP_TICK:
            begin
                // Age out silent peers and close the gaps, keeping the order.
                for (int i = 0; i < member_cnt; i++)
                begin
                    age = c.current_time - member_tab[i].stamp;
                    if (!is_own_address(member_tab[i].id, member_tab[i].port)
                        && age >= {16'd0, cfg_timeout})
                    begin
                        batch.insert(batch.size(), make_report(hmt_pkg::KIND_REMOVED,
                                                               member_tab[i].id,
                                                               member_tab[i].port,
                                                               member_tab[i].heartbeat));
                    end
                    else
                    begin
                        member_tab[keep] = member_tab[i];
                        keep++;
                    end
                end
                member_cnt = keep;
                if (own_beat != 32'hFFFF_FFFF)
                begin
                    own_beat++;
                end
                for (int i = 0; i < member_cnt; i++)
                begin
                    if (is_own_address(member_tab[i].id, member_tab[i].port))
                    begin
                        member_tab[i].heartbeat = own_beat;
                        member_tab[i].stamp = c.current_time;
                    end
                end
                for (int i = 0; i < member_cnt; i++)
                begin
                    batch.insert(batch.size(), make_report(hmt_pkg::KIND_LISTED,
                                                           member_tab[i].id,
                                                           member_tab[i].port,
                                                           member_tab[i].heartbeat));
                end
            end
            hmt_pkg::OP_DUMP:
            begin
                for (int i = 0; i < member_cnt; i++)
                begin
                    batch.insert(batch.size(), make_report(hmt_pkg::KIND_LISTED,
                                                           member_tab[i].id,
                                                           member_tab[i].port,
                                                           member_tab[i].heartbeat));
                end
            end
            default:
            begin
                own_beat = '0;
                member_tab[0] = '{cfg_self_id, cfg_self_port, 32'd0, c.current_time};
                member_cnt = 1;
                batch.insert(batch.size(), make_report(hmt_pkg::KIND_RESTARTED, cfg_self_id,
                                                       cfg_self_port, 32'd0));
            end
        endcase
        // A tick or dump that produces nothing still answers with one empty report.
        if (batch.size() == 0)
        begin
            batch.insert(0, make_report(hmt_pkg::KIND_EMPTY, 32'd0, 16'd0, 32'd0));
        end
        foreach (batch[k])
        begin
            r = batch[k];
            r.entry_count = 6'(member_cnt);
            r.last = (k == batch.size() - 1);
            expected_reports.insert(expected_reports.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Sends one item. The caller stands at a falling edge, and so does the task
    // when it returns. Start stays high after acceptance so that a zero gap
    // lets the next item follow at once.
    task automatic send_item(hmt_pkg::cmd_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        // The item is taken at the first rising edge where busy is low.
        do
            @(posedge clk);
        while (busy);
        predict_table_op(c);
        @(negedge clk);
    endtask

    function automatic hmt_pkg::cmd_t make_cmd(logic [1:0] op, logic [31:0] id,
                                               logic [15:0] port, logic [31:0] beat,
                                               logic [31:0] now);
        hmt_pkg::cmd_t c;
        c.operation = op;
        c.node_id = id;
        c.node_port = port;
        c.heartbeat_in = beat;
        c.current_time = now;
        return c;
    endfunction

    // Tick, dump and restart ignore the merge fields, so those carry noise.
    task automatic send_control(logic [1:0] op, logic [31:0] now);
        send_item(make_cmd(op, $urandom, 16'($urandom), $urandom, now));
    endtask

    // Holds off the sender until every predicted report has come back and the
    // block has dropped busy.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drives one register write for a cycle; the caller drops the write enable
    // after its last write.
    task automatic write_register(logic [hmt_pkg::CFG_IDX_W-1:0] index,
                                  logic [hmt_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        case (index)
            hmt_pkg::CFG_SELF_ID: cfg_self_id = data;
            hmt_pkg::CFG_SELF_PORT: cfg_self_port = data[15:0];
            hmt_pkg::CFG_TIMEOUT: cfg_timeout = data[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Configuration is only changed while the block is idle.
    task automatic apply_settings(logic [31:0] self_id, logic [15:0] self_port,
                                  logic [15:0] timeout);
        wait_idle();
        write_register(hmt_pkg::CFG_SELF_ID, self_id);
        write_register(hmt_pkg::CFG_SELF_PORT, {16'd0, self_port});
        write_register(hmt_pkg::CFG_TIMEOUT, {16'd0, timeout});
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 200)
        begin
            $display("[%0t] mismatch on report %0d: %s", $time, reports_seen, msg);
        end
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Every strobed report is compared with the oldest prediction. Sampling at
    // the rising edge sees the values of the cycle that the edge ends.
    always @(posedge clk)
    begin : report_checker
        hmt_pkg::result_t want;
        if (rst_n && result_strobe)
        begin
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                report_mismatch("report arrived with none expected");
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("kind", 32'(result.kind), 32'(want.kind));
                check_field("entry_id", result.entry_id, want.entry_id);
                check_field("entry_port", 32'(result.entry_port), 32'(want.entry_port));
                check_field("entry_heartbeat", result.entry_heartbeat, want.entry_heartbeat);
                check_field("is_self", 32'(result.is_self), 32'(want.is_self));
                check_field("entry_count", 32'(result.entry_count), 32'(want.entry_count));
                check_field("last", 32'(result.last), 32'(want.last));
            end
        end
    end

    // The watchdog restarts its count on every accepted item and every report.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation and every merge outcome but a drop, ageing across the wrap of the
    // time counter, removal exactly at the timeout, a table without its self
    // entry and a tick on an empty table. Reset values of the registers apply,
    // so the self address is id 0, port 0.
    task automatic test_basic_operations();
        send_control(hmt_pkg::OP_DUMP, 32'd3);
        send_control(hmt_pkg::OP_TICK, 32'd5);
        // A peer alone in the table: the tick bumps the own heartbeat but has
        // no self entry to refresh.
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'hDEAD_0001, 16'd9, 32'd1, 32'd6));
        send_control(hmt_pkg::OP_TICK, 32'd7);
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h1234_5678, 16'd80, 32'd10, 32'd100));
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h1234_5678, 16'd80, 32'd11, 32'd101));
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h1234_5678, 16'd80, 32'd11, 32'd102));
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h1234_5678, 16'd80, 32'd3, 32'd102));
        // Same id on another port is a separate member.
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h1234_5678, 16'd81, 32'd0, 32'd102));
        // All-ones fields, stamped just before the time counter wraps.
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFF0));
        // The self address merged like any other entry.
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'd0, 16'd0, 32'd7, 32'd103));
        send_control(hmt_pkg::OP_DUMP, 32'd104);
        // The all-ones entry is 121 ticks old across the wrap and goes.
        send_control(hmt_pkg::OP_TICK, 32'd105);
        // The entry refreshed at 101 is exactly at the timeout, 102 is one short.
        send_control(hmt_pkg::OP_TICK, 32'd121);
        send_control(hmt_pkg::OP_TICK, 32'd122);
        send_control(hmt_pkg::OP_RESTART, 32'd200);
        send_control(hmt_pkg::OP_TICK, 32'd210);
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'd0, 16'd0, 32'hFFFF_FFFF, 32'd211));
        send_control(hmt_pkg::OP_DUMP, 32'd212);
        send_control(hmt_pkg::OP_TICK, 32'd213);
    endtask

    // Fills the table, merges into it while full, then empties it of peers in
    // one tick, which gives the largest number of reports for one item.
    task automatic test_full_table();
        send_control(hmt_pkg::OP_RESTART, 32'd1000);
        for (int i = 1; i < TABLE_DEPTH; i++)
        begin
            send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h0000_0100 + i, 16'(i), 32'(i),
                               32'd1000 + i));
        end
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'hCAFE_F00D, 16'h7777, 32'd5, 32'd1040));
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h0000_0105, 16'd5, 32'd100, 32'd1041));
        send_control(hmt_pkg::OP_DUMP, 32'd1042);
        send_control(hmt_pkg::OP_TICK, 32'd5000);
    endtask

    // The timeout at zero, one and its largest value.
    task automatic test_timeout_extremes();
        apply_settings(32'hA5A5_0001, 16'h5A5A, 16'd0);
        send_control(hmt_pkg::OP_RESTART, 32'd50);
        for (int i = 0; i < 3; i++)
        begin
            send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h0000_0A00 + i, 16'd1, 32'd1, 32'd50));
        end
        send_control(hmt_pkg::OP_TICK, 32'd50);

        apply_settings(32'hA5A5_0001, 16'h5A5A, 16'hFFFF);
        send_control(hmt_pkg::OP_RESTART, 32'hFFFF_0000);
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h0000_0B00, 16'd2, 32'd4, 32'hFFFF_0000));
        send_control(hmt_pkg::OP_TICK, 32'hFFFF_FFFE);
        send_control(hmt_pkg::OP_TICK, 32'hFFFF_FFFF);

        apply_settings(32'hA5A5_0001, 16'h5A5A, 16'd1);
        send_item(make_cmd(hmt_pkg::OP_MERGE, 32'h0000_0C00, 16'd3, 32'd9, 32'd7));
        send_control(hmt_pkg::OP_TICK, 32'd7);
        send_control(hmt_pkg::OP_TICK, 32'd8);
    endtask

    // One setting of the registers followed by random traffic. Most items are
    // merges from a small pool of addresses, so members come back, get newer
    // heartbeats, fill the table and age out; the rest are ticks, dumps,
    // restarts and items with every field random.
    task automatic random_phase(logic [31:0] self_id, logic [15:0] self_port,
                                logic [15:0] timeout, int n_items);
        hmt_pkg::cmd_t c;
        int sel;
        int slot;
        int bump;
        int span;
        apply_settings(self_id, self_port, timeout);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_id[i] = $urandom;
            pool_port[i] = 16'($urandom);
            pool_beat[i] = $urandom;
            if (i > 0 && $urandom_range(0, 3) == 0)
            begin
                pool_id[i] = pool_id[i - 1];
            end
        end
        pool_id[0] = self_id;
        pool_port[0] = self_port;
        time_now = $urandom;
        span = int'(timeout);
        if ($urandom_range(0, 1) == 0)
        begin
            send_control(hmt_pkg::OP_RESTART, time_now);
        end
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 16 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 29) == 0)
            begin
                wait_idle();
            end
            c = make_cmd(hmt_pkg::OP_DUMP, $urandom, 16'($urandom), $urandom, time_now);
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                slot = $urandom_range(0, POOL_SIZE - 1);
                bump = $urandom_range(0, 3);
                c.operation = hmt_pkg::OP_MERGE;
                c.node_id = pool_id[slot];
                c.node_port = pool_port[slot];
                if (bump == 0)
                begin
                    c.heartbeat_in = pool_beat[slot] - $urandom_range(0, 1);
                end
                else
                begin
                    c.heartbeat_in = pool_beat[slot] + bump;
                    pool_beat[slot] = c.heartbeat_in;
                end
                time_now = time_now + $urandom_range(0, 2);
                c.current_time = time_now;
            end
            else if (sel < 80)
            begin
                c.operation = hmt_pkg::OP_TICK;
                if ($urandom_range(0, 4) == 0)
                begin
                    time_now = time_now + $urandom_range(0, 2 * span);
                end
                else
                begin
                    time_now = time_now + $urandom_range(0, span / 4 + 1);
                end
                c.current_time = time_now;
            end
            else if (sel < 90)
            begin
                c.operation = hmt_pkg::OP_DUMP;
            end
            else if (sel < 93)
            begin
                c.operation = hmt_pkg::OP_RESTART;
            end
            else
            begin
                c = make_cmd(2'($urandom), $urandom, 16'($urandom), $urandom, $urandom);
            end
            send_item(c);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase($urandom, 16'($urandom), hmt_pkg::TIMEOUT_RESET, 50);
        random_phase(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 50);
        random_phase(32'd0, 16'd0, 16'hFFFF, 50);
        random_phase($urandom, 16'($urandom), 16'd0, 50);
        random_phase($urandom, 16'($urandom), 16'($urandom_range(2, 60)), 50);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        reports_seen = 0;
        stall_cycles = 0;
        no_idle = 1'b0;
        // The predicted state after reset: empty table, registers at reset values.
        member_cnt = 0;
        own_beat = '0;
        cfg_self_id = '0;
        cfg_self_port = '0;
        cfg_timeout = hmt_pkg::TIMEOUT_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_operations();
        test_full_table();
        test_timeout_extremes();
        test_random_traffic();

        // Let every report come back, then keep watching for stray ones.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/hmt_pkg.sv
sv/hmt_cell.sv
sv/heartbeat_membership_table_top.sv
dv/tb_heartbeat_membership_table_top.sv
